// ===== sv/irq_line_penalty_allocator_defines.svh =====
// Assertion macros for the interrupt line penalty allocator.
// No dependencies; included by files that carry concurrent checks.
`ifndef IRQ_LINE_PENALTY_ALLOCATOR_DEFINES_SVH
`define IRQ_LINE_PENALTY_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Checks are clocked on clk and held off while rst_n is low.
`define ILPA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ilpa: assertion failed");
`define ILPA_NEVER(label, cond) \
    `ILPA_ASSERT(label, !(cond))
`else
`define ILPA_ASSERT(label, prop)
`define ILPA_NEVER(label, cond)
`endif

`endif

// ===== sv/ilpa_pkg.sv =====
// Shared types, constants and reset table for the interrupt line penalty allocator.
// No dependencies; used by ilpa_cell, ilpa_update and the top level.
package ilpa_pkg;

    localparam int NUM_LINES    = 16;
    localparam int PENALTY_BITS = 24;
    localparam int LINE_W       = $clog2(NUM_LINES);
    localparam int PADDR_W      = 3;

    localparam logic [PENALTY_BITS-1:0] PEN_MAX = {PENALTY_BITS{1'b1}};
    localparam logic [PENALTY_BITS-1:0] CLR_LO  = PENALTY_BITS'(100);
    localparam logic [PENALTY_BITS-1:0] CLR_HI  = PENALTY_BITS'(100000);
    localparam logic [7:0]  PEN_STEP     = 8'd100;
    localparam logic [7:0]  RECORD_STEP  = 8'd1;
    localparam logic [15:0] USABLE_RESET = 16'hfff8;

    // commands
    localparam logic [1:0] CMD_PEN_LINE   = 2'd0;
    localparam logic [1:0] CMD_PEN_OTHERS = 2'd1;
    localparam logic [1:0] CMD_RECORD     = 2'd2;
    localparam logic [1:0] CMD_LOOKUP     = 2'd3;

    // result status codes
    localparam logic [2:0] ST_UPDATE   = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_ASSIGNED = 3'd2;
    localparam logic [2:0] ST_GUESSED  = 3'd3;
    localparam logic [2:0] ST_FAILED   = 3'd4;

    // config register index
    localparam logic REG_USABLE = 1'b0;

    localparam logic [19:0] DEFAULT_PEN [16] = '{
        20'd1000000, 20'd1000000, 20'd1000000, 20'd1000,
        20'd1000,    20'd0,       20'd1000,    20'd1000,
        20'd0,       20'd0,       20'd0,       20'd0,
        20'd1000,    20'd100000,  20'd100000,  20'd100000
    };

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  irq_number;
        logic [15:0] irq_set;
        logic [15:0] free_irqs;
        logic        try_assign;
        logic [3:0]  current_irq;
        logic        can_set;
        logic        is_vga;
        logic        set_ok;
        logic [7:0]  share_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] chosen_irq;
        logic [3:0] best_candidate;
    } out_item_t;

    // what the head update unit needs for one pass
    typedef struct packed {
        logic [1:0]  command;
        logic        charge;
        logic        charge_en;
        logic [7:0]  irq_number;
        logic [15:0] irq_set;
        logic [3:0]  chosen;
        logic [7:0]  share_count;
    } upd_ctl_t;

    function automatic logic [PENALTY_BITS-1:0] pen_reset(int line);
        logic [PENALTY_BITS-1:0] v;
        v = '0;
        if (line < 16)
        begin
            v = PENALTY_BITS'(DEFAULT_PEN[line[3:0]]);
        end
        return v;
    endfunction

endpackage

// ===== sv/irq_line_penalty_allocator.sv =====
// Top level of the interrupt line penalty allocator: control, scan, ring and APB register.
// Depends on ilpa_pkg, ilpa_cell, ilpa_update and irq_line_penalty_allocator_defines.svh.
//
// Penalties live in a ring of NUM_LINES cells that rotates one line per cycle, while a
// command scans or charges, through a shared update unit at its head; one transaction
// is handled at a time. An update command makes one ring revolution and then passes
// through S_DONE before the next command can be taken; a lookup makes one ring
// revolution to scan for the lowest penalty, decides in S_DECIDE, and makes a second
// revolution to charge the chosen line. Results sit in an output register, so a new
// command is accepted while the previous result is still waiting; a finished command
// holds in S_DONE until that register is empty or being emptied. usable_irqs is at
// byte address 0 and should only be written while no command is in flight.
`include "irq_line_penalty_allocator_defines.svh"

module irq_line_penalty_allocator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    output logic                              cmd_ready,
    input  ilpa_pkg::in_item_t                cmd,
    output logic                              res_valid,
    input  logic                              res_ready,
    output ilpa_pkg::out_item_t               res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ilpa_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int N  = ilpa_pkg::NUM_LINES;
    localparam int LW = ilpa_pkg::LINE_W;
    localparam int PB = ilpa_pkg::PENALTY_BITS;
    localparam logic [LW-1:0] LAST = LW'(N - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_CHARGE,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [LW-1:0]       cnt_reg;
    ilpa_pkg::in_item_t  item_reg;
    logic [15:0]         scan_mask_reg;
    logic [15:0]         excl_mask_reg;
    logic [LW-1:0]       best_idx_reg;
    logic [PB-1:0]       best_pen_reg;
    logic [2:0]          status_reg;
    logic [3:0]          chosen_reg;
    logic                res_valid_reg;
    ilpa_pkg::out_item_t res_reg;
    logic [15:0]         usable_reg;

    logic [PB-1:0]       ring_out [N];
    logic [PB-1:0]       head_next;
    logic                shift;
    ilpa_pkg::upd_ctl_t  ctl;
    logic [15:0]         scan_sh;
    logic                better;
    logic                cfg_wr;
    logic                best_nz;
    logic                can_assign;
    logic                single_line;
    logic [2:0]          dec_status;
    logic [3:0]          dec_chosen;

    // ring of cells, head is cell 0, head update re-enters at the tail
    assign shift = (state_reg == S_SCAN) || (state_reg == S_CHARGE);

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        logic [PB-1:0] cell_in;
        if (i == N - 1)
        begin : g_tail
            assign cell_in = head_next;
        end
        else
        begin : g_link
            assign cell_in = ring_out[i + 1];
        end
        ilpa_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .reset_value (ilpa_pkg::pen_reset(i)),
            .shift       (shift),
            .data_in     (cell_in),
            .data_out    (ring_out[i])
        );
    end

    assign ctl.command     = item_reg.command;
    assign ctl.charge      = (state_reg == S_CHARGE);
    assign ctl.charge_en   = (status_reg != ilpa_pkg::ST_FAILED);
    assign ctl.irq_number  = item_reg.irq_number;
    assign ctl.irq_set     = item_reg.irq_set;
    assign ctl.chosen      = chosen_reg;
    assign ctl.share_count = item_reg.share_count;

    ilpa_update u_update (
        .ctl       (ctl),
        .line      (cnt_reg),
        .head      (ring_out[0]),
        .head_next (head_next)
    );

    // scan compare against the best penalty so far
    assign scan_sh = scan_mask_reg >> cnt_reg;
    assign better  = item_reg.try_assign && scan_sh[0] && (ring_out[0] < best_pen_reg);

    // lookup decision
    assign best_nz     = (best_idx_reg != '0);
    assign can_assign  = item_reg.can_set && !item_reg.is_vga && item_reg.set_ok;
    assign single_line = (excl_mask_reg == (16'd1 << best_idx_reg));

    always_comb
    begin
        if (item_reg.current_irq != 4'd0)
        begin
            dec_status = ilpa_pkg::ST_FOUND;
            dec_chosen = item_reg.current_irq;
        end
        else if (best_nz && can_assign)
        begin
            dec_status = ilpa_pkg::ST_ASSIGNED;
            dec_chosen = 4'(best_idx_reg);
        end
        else if (best_nz && single_line)
        begin
            dec_status = ilpa_pkg::ST_GUESSED;
            dec_chosen = 4'(best_idx_reg);
        end
        else
        begin
            dec_status = ilpa_pkg::ST_FAILED;
            dec_chosen = 4'd0;
        end
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ilpa_pkg::REG_USABLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            item_reg      <= '0;
            scan_mask_reg <= '0;
            excl_mask_reg <= '0;
            best_idx_reg  <= '0;
            best_pen_reg  <= '0;
            status_reg    <= ilpa_pkg::ST_UPDATE;
            chosen_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
            usable_reg    <= ilpa_pkg::USABLE_RESET;
        end
        else
        begin
            if (cfg_wr)
            begin
                usable_reg <= pwdata[15:0];
            end
            // in S_DONE the valid flag is handled by the refill below
            if (res_valid_reg && res_ready && (state_reg != S_DONE))
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        item_reg      <= cmd;
                        scan_mask_reg <= cmd.irq_set & usable_reg & cmd.free_irqs;
                        excl_mask_reg <= cmd.irq_set & usable_reg;
                        best_idx_reg  <= '0;
                        status_reg    <= ilpa_pkg::ST_UPDATE;
                        chosen_reg    <= '0;
                        cnt_reg       <= '0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (item_reg.command == ilpa_pkg::CMD_LOOKUP)
                    begin
                        // line 0 seeds the best penalty whatever the masks say
                        if (cnt_reg == '0)
                        begin
                            best_pen_reg <= ring_out[0];
                        end
                        else if (better)
                        begin
                            best_pen_reg <= ring_out[0];
                            best_idx_reg <= cnt_reg;
                        end
                    end
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (item_reg.command == ilpa_pkg::CMD_LOOKUP)
                                     ? S_DECIDE : S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    status_reg <= dec_status;
                    chosen_reg <= dec_chosen;
                    state_reg  <= S_CHARGE;
                end
                S_CHARGE:
                begin
                    if (cnt_reg == LAST)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_reg.status         <= status_reg;
                        res_reg.chosen_irq     <= chosen_reg;
                        res_reg.best_candidate <= 4'(best_idx_reg);
                        res_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == ilpa_pkg::REG_USABLE) ? {16'd0, usable_reg} : 32'd0;

    `ILPA_ASSERT(a_res_from_done, $rose(res_valid_reg) |-> $past(state_reg == S_DONE))
    `ILPA_NEVER(a_cnt_range, int'(cnt_reg) >= N)
    `ILPA_ASSERT(a_failed_no_line,
        res_valid_reg && (res_reg.status == ilpa_pkg::ST_FAILED) |-> res_reg.chosen_irq == 4'd0)
    `ILPA_ASSERT(a_update_zero,
        res_valid_reg && (res_reg.status == ilpa_pkg::ST_UPDATE)
        |-> (res_reg.chosen_irq == 4'd0) && (res_reg.best_candidate == 4'd0))

endmodule

// ===== sv/ilpa_cell.sv =====
// One cell of the penalty ring: holds a single line's penalty.
// Depends on ilpa_pkg for the penalty width.
module ilpa_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [ilpa_pkg::PENALTY_BITS-1:0]    reset_value,
    input  logic                                 shift,
    input  logic [ilpa_pkg::PENALTY_BITS-1:0]    data_in,
    output logic [ilpa_pkg::PENALTY_BITS-1:0]    data_out
);

    logic [ilpa_pkg::PENALTY_BITS-1:0] pen_reg;

    // reset_value is tied to a constant per cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= reset_value;
        end
        else if (shift)
        begin
            pen_reg <= data_in;
        end
    end

    assign data_out = pen_reg;

endmodule

// ===== sv/ilpa_update.sv =====
// Head update unit: modifies the penalty leaving the ring head.
// Depends on ilpa_pkg for commands, constants and the control struct.
module ilpa_update (
    input  ilpa_pkg::upd_ctl_t                   ctl,
    input  logic [ilpa_pkg::LINE_W-1:0]          line,
    input  logic [ilpa_pkg::PENALTY_BITS-1:0]    head,
    output logic [ilpa_pkg::PENALTY_BITS-1:0]    head_next
);

    localparam int PB = ilpa_pkg::PENALTY_BITS;

    logic [7:0]    line_ext;
    logic [7:0]    rec_line;
    logic [15:0]   set_sh;
    logic          hit;
    logic          clear;
    logic [7:0]    amount;
    logic [PB-1:0] base;
    logic [PB:0]   sum;
    logic [PB-1:0] sat;

    assign line_ext = 8'(line);
    // out-of-range lines are recorded against line 0
    assign rec_line = (ctl.irq_number < 8'(ilpa_pkg::NUM_LINES)) ? ctl.irq_number : 8'd0;
    assign set_sh   = ctl.irq_set >> line;

    always_comb
    begin
        hit    = 1'b0;
        clear  = 1'b0;
        amount = '0;
        if (ctl.charge)
        begin
            hit    = ctl.charge_en && (line_ext == {4'b0, ctl.chosen});
            amount = ctl.share_count;
        end
        else
        begin
            case (ctl.command)
                ilpa_pkg::CMD_PEN_LINE:
                begin
                    hit    = (line_ext == ctl.irq_number);
                    amount = ilpa_pkg::PEN_STEP;
                end
                ilpa_pkg::CMD_PEN_OTHERS:
                begin
                    hit    = (ctl.irq_set != 16'd0) && !set_sh[0];
                    amount = ilpa_pkg::PEN_STEP;
                end
                ilpa_pkg::CMD_RECORD:
                begin
                    hit    = (line_ext == rec_line);
                    clear  = (head >= ilpa_pkg::CLR_LO) && (head < ilpa_pkg::CLR_HI);
                    amount = ilpa_pkg::RECORD_STEP;
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    assign base      = clear ? '0 : head;
    assign sum       = {1'b0, base} + (PB + 1)'(amount);
    assign sat       = sum[PB] ? ilpa_pkg::PEN_MAX : sum[PB-1:0];
    assign head_next = hit ? sat : head;

endmodule
